[sv/wwds_pkg.sv]
// ----------------------------------------------------------------------------
// wwds_pkg
// shared constants, types and helpers for the weighted window downsampler
// ----------------------------------------------------------------------------
package wwds_pkg;

    localparam int TAPS         = 4;
    localparam int MAX_CHANNELS = 256;
    localparam int WEIGHT_REGS  = 4;

    // history rows kept per channel (at least one)
    localparam int HIST_ROWS = (TAPS > 1) ? TAPS - 1 : 1;
    // taps that can really be used: limited by the weight registers
    localparam int TAP_LIM   = (TAPS < WEIGHT_REGS) ? TAPS : WEIGHT_REGS;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int CHAN_OUT_W = 8;
    localparam int TAPCNT_W   = 3;
    localparam int CHCNT_W    = 9;
    localparam int FRAMES_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // unsigned weight times signed sample, summed over up to four taps
    localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST     = 3'd2;
    localparam logic [CHCNT_W-1:0]  CHANNEL_COUNT_RST = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_01_RST     = 16'd32768;
    localparam logic [WEIGHT_W-1:0] WEIGHT_23_RST     = 16'd0;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX        = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT     = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_WEIGHT_0      = 3'd2,
        CFG_WEIGHT_1      = 3'd3,
        CFG_WEIGHT_2      = 3'd4,
        CFG_WEIGHT_3      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sequence_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [CHAN_OUT_W-1:0]      channel;
    } t_out_item;

    typedef logic [HIST_ROWS-1:0][SAMPLE_W-1:0]   t_hist_row;
    typedef logic [WEIGHT_REGS-1:0][WEIGHT_W-1:0] t_weights;

    // item going into the history memory stage
    typedef struct packed {
        logic                  valid;
        logic                  produce;
        logic                  pad;
        logic [SAMPLE_W-1:0]   sample;
        logic [CH_W-1:0]       addr;
        logic [CHAN_OUT_W-1:0] chan;
        logic [TAPCNT_W-1:0]   taps;
    } t_hreq;

    // window of samples handed to the multiply stage, oldest first
    typedef struct packed {
        logic                               valid;
        logic [CHAN_OUT_W-1:0]              chan;
        logic [TAP_LIM-1:0][SAMPLE_W-1:0]   elem;
    } t_win;

    function automatic logic [TAPCNT_W-1:0] eff_taps(input logic [TAPCNT_W-1:0] tc);
        logic [TAPCNT_W-1:0] t;
        t = tc;
        if (t == '0) t = TAPCNT_W'(1);
        if (int'(t) > TAP_LIM) t = TAPCNT_W'(TAP_LIM);
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] eff_chans(input logic [CHCNT_W-1:0] cc);
        int unsigned v;
        v = 32'(cc);
        if (v == 0) v = 1;
        if (v > MAX_CHANNELS) v = MAX_CHANNELS;
        return v[CNT_W-1:0];
    endfunction

    function automatic logic [CHAN_OUT_W-1:0] chan_out(input logic [CH_W-1:0] c);
        logic [CH_W+CHAN_OUT_W-1:0] t;
        t = {{CHAN_OUT_W{1'b0}}, c};
        return t[CHAN_OUT_W-1:0];
    endfunction

endpackage

[sv/wwds_hist.sv]
// ----------------------------------------------------------------------------
// wwds_hist
// per-channel history memory with read-modify-write and write forwarding
// ----------------------------------------------------------------------------
module wwds_hist (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wwds_pkg::t_hreq i_req,
    output wwds_pkg::t_win  o_win
);

    wwds_pkg::t_hist_row r_mem [wwds_pkg::MAX_CHANNELS];
    wwds_pkg::t_hist_row r_rd;
    wwds_pkg::t_hreq     r_s1;

    logic                        r_fwd_v;
    logic [wwds_pkg::CH_W-1:0]   r_fwd_addr;
    wwds_pkg::t_hist_row         r_fwd_row;

    wwds_pkg::t_hist_row           row_old;
    wwds_pkg::t_hist_row           n_row;
    logic [wwds_pkg::SAMPLE_W-1:0] x;

    // memory: read on accept, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rd <= r_mem[i_req.addr];
        end
        if (r_s1.valid) begin
            r_mem[r_s1.addr] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_fwd_v    <= 1'b0;
        end else begin
            r_s1    <= i_req;
            r_fwd_v <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1.addr;
        r_fwd_row  <= n_row;
    end

    always_comb begin
        // the previous item's write lands on the same edge as this read
        if (r_fwd_v && (r_fwd_addr == r_s1.addr)) begin
            row_old = r_fwd_row;
        end else begin
            row_old = r_rd;
        end
        x = r_s1.pad ? row_old[0] : r_s1.sample;

        n_row[0] = x;
        for (int i = 1; i < wwds_pkg::HIST_ROWS; i++) begin
            n_row[i] = row_old[i-1];
        end

        o_win.valid = r_s1.valid & r_s1.produce;
        o_win.chan  = r_s1.chan;
        for (int k = 0; k < wwds_pkg::TAP_LIM; k++) begin
            o_win.elem[k] = '0;
            if (k + 1 == int'(r_s1.taps)) begin
                o_win.elem[k] = x;
            end else if (k + 1 < int'(r_s1.taps)) begin
                for (int j = 0; j < wwds_pkg::HIST_ROWS; j++) begin
                    if (j == int'(r_s1.taps) - 2 - k) begin
                        o_win.elem[k] = row_old[j];
                    end
                end
            end
        end
    end

endmodule

[sv/wwds_mac.sv]
// ----------------------------------------------------------------------------
// wwds_mac
// parallel weight multiply, then sum, round half up and saturate
// ----------------------------------------------------------------------------
module wwds_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wwds_pkg::t_win      i_win,
    input  wwds_pkg::t_weights  i_weights,
    output logic                o_push,
    output wwds_pkg::t_out_item o_res
);

    logic                                r_v;
    logic [wwds_pkg::CHAN_OUT_W-1:0]     r_chan;
    logic signed [wwds_pkg::PROD_W-1:0]  r_prod [wwds_pkg::TAP_LIM];

    logic signed [wwds_pkg::SUM_W-1:0]                 sum;
    logic signed [wwds_pkg::SUM_W-1:0]                 rnd;
    logic signed [wwds_pkg::SUM_W-wwds_pkg::FRAC_W-1:0] sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_win.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= i_win.chan;
        for (int k = 0; k < wwds_pkg::TAP_LIM; k++) begin
            r_prod[k] <= $signed({1'b0, i_weights[k]}) * $signed(i_win.elem[k]);
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < wwds_pkg::TAP_LIM; k++) begin
            sum = sum + wwds_pkg::SUM_W'(r_prod[k]);
        end
        rnd = sum + wwds_pkg::SUM_W'(32768);
        sh  = rnd[wwds_pkg::SUM_W-1:wwds_pkg::FRAC_W];

        if (sh > 32767) begin
            o_res.value = 16'sh7fff;
        end else if (sh < -32768) begin
            o_res.value = 16'sh8000;
        end else begin
            o_res.value = sh[wwds_pkg::SAMPLE_W-1:0];
        end
        o_res.channel = r_chan;
    end

    assign o_push = r_v;

endmodule

[sv/wwds_outq.sv]
// ----------------------------------------------------------------------------
// wwds_outq
// small result queue that decouples the pipeline from output stalls
// ----------------------------------------------------------------------------
module wwds_outq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  wwds_pkg::t_out_item               i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output wwds_pkg::t_out_item               o_data,
    output logic [wwds_pkg::OUTQ_CNT_W-1:0]   o_count
);

    wwds_pkg::t_out_item                   r_mem [wwds_pkg::OUTQ_DEPTH];
    logic [wwds_pkg::OUTQ_PTR_W-1:0]       r_wr;
    logic [wwds_pkg::OUTQ_PTR_W-1:0]       r_rd;
    logic [wwds_pkg::OUTQ_CNT_W-1:0]       r_count;
    logic [wwds_pkg::OUTQ_CNT_W-1:0]       n_count;
    logic                                  pop;

    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

[sv/weighted_window_downsample.sv]
// ----------------------------------------------------------------------------
// weighted_window_downsample
// per-channel weighted sum over a sliding window of frames
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_item  (action, sample, sequence_start)
//  out      output     o_out_valid / i_out_ready  o_out_item (value, channel)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one item per cycle while o_in_ready is high; on its way to the output a result passes
//  history memory read, then write back and multiply, then sum into the queue
//  the history memory port (one read, one write a cycle) sets the rate
//  reset clears the counters, the queue and the config; history stays as is
//  output stalls fill the 4-entry queue; input stalls once queue plus pipeline
//  hold 4 results
//
module weighted_window_downsample (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wwds_pkg::t_in_item                i_in_item,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wwds_pkg::t_out_item               o_out_item,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wwds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wwds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [wwds_pkg::TAPCNT_W-1:0] r_tap_count;
    logic [wwds_pkg::CHCNT_W-1:0]  r_channel_count;
    wwds_pkg::t_weights            r_weights;

    // stream position
    logic [wwds_pkg::CH_W-1:0]     r_pos;
    logic [wwds_pkg::FRAMES_W-1:0] r_frames;
    logic [wwds_pkg::CH_W-1:0]     n_pos;
    logic [wwds_pkg::FRAMES_W-1:0] n_frames;

    logic                          in_fire;
    logic                          cfg_fire;
    logic [wwds_pkg::TAPCNT_W-1:0] taps;
    logic [wwds_pkg::CNT_W-1:0]    chans;
    logic [wwds_pkg::CH_W-1:0]     pos0;
    logic [wwds_pkg::FRAMES_W-1:0] fs0;
    logic [wwds_pkg::CH_W-1:0]     c;
    logic [wwds_pkg::CNT_W:0]      c_inc;
    logic                          wrap;
    logic                          produce;

    wwds_pkg::t_hreq               hreq;
    wwds_pkg::t_win                win;
    logic                          res_push;
    wwds_pkg::t_out_item           res;
    logic [wwds_pkg::OUTQ_CNT_W-1:0] q_count;
    logic [wwds_pkg::OUTQ_CNT_W:0]   inflight;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count     <= wwds_pkg::TAP_COUNT_RST;
            r_channel_count <= wwds_pkg::CHANNEL_COUNT_RST;
            r_weights[0]    <= wwds_pkg::WEIGHT_01_RST;
            r_weights[1]    <= wwds_pkg::WEIGHT_01_RST;
            r_weights[2]    <= wwds_pkg::WEIGHT_23_RST;
            r_weights[3]    <= wwds_pkg::WEIGHT_23_RST;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                wwds_pkg::CFG_TAP_COUNT: begin
                    r_tap_count <= i_cfg_data[wwds_pkg::TAPCNT_W-1:0];
                end
                wwds_pkg::CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[wwds_pkg::CHCNT_W-1:0];
                end
                wwds_pkg::CFG_WEIGHT_0: begin
                    r_weights[0] <= i_cfg_data;
                end
                wwds_pkg::CFG_WEIGHT_1: begin
                    r_weights[1] <= i_cfg_data;
                end
                wwds_pkg::CFG_WEIGHT_2: begin
                    r_weights[2] <= i_cfg_data;
                end
                wwds_pkg::CFG_WEIGHT_3: begin
                    r_weights[3] <= i_cfg_data;
                end
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // room check: queue plus every result still in the pipeline
    assign inflight   = (wwds_pkg::OUTQ_CNT_W+1)'(q_count)
                      + (wwds_pkg::OUTQ_CNT_W+1)'(win.valid)
                      + (wwds_pkg::OUTQ_CNT_W+1)'(res_push);
    assign o_in_ready = (inflight < (wwds_pkg::OUTQ_CNT_W+1)'(wwds_pkg::OUTQ_DEPTH));
    assign in_fire    = i_in_valid & o_in_ready;

    always_comb begin
        taps  = wwds_pkg::eff_taps(r_tap_count);
        chans = wwds_pkg::eff_chans(r_channel_count);

        // sequence start clears position and frame count before this item
        pos0 = i_in_item.sequence_start ? '0 : r_pos;
        fs0  = i_in_item.sequence_start ? '0 : r_frames;

        // channel count may have shrunk under the position
        if ((wwds_pkg::CNT_W+1)'(pos0) >= (wwds_pkg::CNT_W+1)'(chans)) begin
            c = '0;
        end else begin
            c = pos0;
        end

        c_inc = (wwds_pkg::CNT_W+1)'(c) + 1'b1;
        wrap  = (c_inc >= (wwds_pkg::CNT_W+1)'(chans));
        n_pos = wrap ? '0 : wwds_pkg::CH_W'(c_inc);

        n_frames = fs0;
        if (wrap && (fs0 != wwds_pkg::FRAMES_MAX)) begin
            n_frames = fs0 + 1'b1;
        end

        // window full once tap_count-1 frames are behind us
        produce = ((wwds_pkg::FRAMES_W+1)'(fs0) + 1'b1)
                >= (wwds_pkg::FRAMES_W+1)'(taps);

        hreq.valid   = in_fire;
        hreq.produce = produce;
        hreq.pad     = i_in_item.action;
        hreq.sample  = i_in_item.sample;
        hreq.addr    = c;
        hreq.chan    = wwds_pkg::chan_out(c);
        hreq.taps    = taps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_frames <= '0;
        end else if (in_fire) begin
            r_pos    <= n_pos;
            r_frames <= n_frames;
        end
    end

    wwds_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hreq),
        .o_win   (win)
    );

    wwds_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (win),
        .i_weights (r_weights),
        .o_push    (res_push),
        .o_res     (res)
    );

    wwds_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_item),
        .o_count (q_count)
    );

endmodule
